/* rtl/spimf_pkg.sv */
// Shared types, codes and helpers for the SPI master with FIFOs.
package spimf_pkg;

    localparam int FIFO_DEPTH_DEF = 8;
    localparam int SELECT_COUNT   = 4;
    localparam int SEL_LINES      = 4;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RX    = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    localparam logic [9:0] REG_CTL1   = 10'd0;
    localparam logic [9:0] REG_SELECT = 10'd1;
    localparam logic [9:0] REG_STATUS = 10'd2;
    localparam logic [9:0] REG_DATA   = 10'd3;

    // control 1 bit positions
    localparam int CTL_SPE    = 0;
    localparam int CTL_MSTR   = 1;
    localparam int CTL_TXEIE  = 2;
    localparam int CTL_RXNEIE = 3;
    localparam int CTL_ERRIE  = 4;

    // status bit positions
    localparam int STAT_TXE  = 0;
    localparam int STAT_RXNE = 1;
    localparam int STAT_OVR  = 2;

    localparam logic [7:0] EMPTY_READ = 8'hFF;
    localparam logic [7:0] SEL_MASK   = 8'h03;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } spimf_req_t;

    typedef struct packed {
        logic [7:0]           read_data;
        logic                 tx_valid;
        logic [7:0]           tx_byte;
        logic                 last;
        logic                 irq_level;
        logic [SEL_LINES-1:0] chip_selects;
    } spimf_rsp_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // Active-low select pattern for one slave index.
    function automatic logic [SEL_LINES-1:0] select_pattern(input logic [1:0] idx);
        logic [SEL_LINES-1:0] lines;
        lines = '1;
        for (int i = 0; i < SEL_LINES; i++)
        begin
            if ((i < SELECT_COUNT) && (idx == 2'(i)))
            begin
                lines[i] = 1'b0;
            end
        end
        return lines;
    endfunction

endpackage

/* rtl/spimf_fifo.sv */
// Byte FIFO with a single memory and registered read data.
module spimf_fifo
    import spimf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] wr_data,
    input  logic       pop,
    output logic [7:0] rd_data,
    output fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == LAST_ADDR) ? '0 : tail_reg + AW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage carries no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != FULL_CNT)
        else $error("fifo push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("fifo pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fifo count out of range");
`endif

endmodule

/* rtl/spi_master_with_fifos_unit.sv */
// SPI master controller with transmit and receive FIFOs: top level.
//
// Each request transaction is one register access (read, write), a byte
// returned by the slave, or a no-op. Register map by word offset: 0 control 1
// (bit 0 enable, 1 master, 2 TX-empty irq enable, 3 RX-not-empty irq enable,
// 4 error irq enable), 1 chip-select index (2 bits), 2 status (bit 0 TX
// empty, bit 1 RX not empty, bit 2 overrun; writing 1 to bit 2 clears
// overrun), 3 data (write queues a TX byte, read pops an RX byte or gives
// 0xFF when empty). An accepted data write in master mode (enabled, TX FIFO
// not full) drains the whole TX FIFO and yields one response transaction per
// byte sent; everything else yields one response. The last flag marks the
// final response of a request, and every response carries the interrupt level
// and active-low chip selects as they stand after the request is done.
// Sequencing: a request is taken only when the sequencer is idle; every request
// other than a draining data write goes through accept, execute and load the
// response (an RX pop fits in the execute step), and a draining data write,
// after accept and execute, alternates one pop and one response load per byte,
// as the FIFO memory has a single registered read port. A finished response
// waits in the output register while the next request is accepted; the
// sequencer stalls only when it must load a new response into a full slot.
module spi_master_with_fifos_unit
    import spimf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  spimf_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output spimf_rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_POP,
        S_SEND
    } state_t;

    state_t               state_reg, state_next;
    spimf_req_t           req_reg, req_next;
    logic [7:0]           ctl_reg, ctl_next;
    logic [1:0]           sel_idx_reg, sel_idx_next;
    logic                 ovr_reg, ovr_next;
    logic [SEL_LINES-1:0] lines_reg, lines_next;
    logic [7:0]           rd_hold_reg, rd_hold_next;
    logic                 rd_from_rx_reg, rd_from_rx_next;
    spimf_rsp_t           rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic       tx_push, tx_pop, rx_push, rx_pop;
    logic [7:0] tx_rd_data, rx_rd_data;
    fifo_stat_t tx_stat, rx_stat;
    logic       rsp_free;
    logic       txe_eff;
    logic       irq;

    spimf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (tx_push),
        .wr_data (req_reg.write_data),
        .pop     (tx_pop),
        .rd_data (tx_rd_data),
        .stat    (tx_stat)
    );

    spimf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rx_push),
        .wr_data (req_reg.rx_byte),
        .pop     (rx_pop),
        .rd_data (rx_rd_data),
        .stat    (rx_stat)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // A drain always ends with the TX FIFO empty, so its responses report TXE.
    assign txe_eff = tx_stat.empty || (state_reg == S_POP) || (state_reg == S_SEND);
    assign irq = (txe_eff && ctl_reg[CTL_TXEIE])
              || (!rx_stat.empty && ctl_reg[CTL_RXNEIE])
              || (ovr_reg && ctl_reg[CTL_ERRIE]);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        ctl_next        = ctl_reg;
        sel_idx_next    = sel_idx_reg;
        ovr_next        = ovr_reg;
        lines_next      = lines_reg;
        rd_hold_next    = rd_hold_reg;
        rd_from_rx_next = rd_from_rx_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        tx_push         = 1'b0;
        tx_pop          = 1'b0;
        rx_push         = 1'b0;
        rx_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rd_hold_next    = '0;
                rd_from_rx_next = 1'b0;
                state_next      = S_RESP;
                case (mode_t'(req_reg.mode))
                    MODE_READ:
                    begin
                        case (req_reg.reg_index)
                            REG_CTL1:   rd_hold_next = ctl_reg;
                            REG_SELECT: rd_hold_next = {6'b0, sel_idx_reg};
                            REG_STATUS:
                            begin
                                rd_hold_next[STAT_TXE]  = tx_stat.empty;
                                rd_hold_next[STAT_RXNE] = !rx_stat.empty;
                                rd_hold_next[STAT_OVR]  = ovr_reg;
                            end
                            REG_DATA:
                            begin
                                if (!rx_stat.empty)
                                begin
                                    rx_pop          = 1'b1;
                                    rd_from_rx_next = 1'b1;
                                end
                                else
                                begin
                                    rd_hold_next = EMPTY_READ;
                                end
                            end
                            default: rd_hold_next = '0;
                        endcase
                    end

                    MODE_WRITE:
                    begin
                        case (req_reg.reg_index)
                            REG_CTL1:
                            begin
                                ctl_next = req_reg.write_data;
                                if (!req_reg.write_data[CTL_SPE])
                                begin
                                    lines_next = '1;
                                end
                                else if (req_reg.write_data[CTL_MSTR])
                                begin
                                    lines_next = select_pattern(sel_idx_reg);
                                end
                            end
                            REG_SELECT:
                            begin
                                sel_idx_next = 2'(req_reg.write_data & SEL_MASK);
                                if (ctl_reg[CTL_SPE] && ctl_reg[CTL_MSTR])
                                begin
                                    lines_next = select_pattern(sel_idx_next);
                                end
                            end
                            REG_STATUS:
                            begin
                                if (req_reg.write_data[STAT_OVR])
                                begin
                                    ovr_next = 1'b0;
                                end
                            end
                            REG_DATA:
                            begin
                                if (ctl_reg[CTL_SPE] && !tx_stat.full)
                                begin
                                    tx_push = 1'b1;
                                    if (ctl_reg[CTL_MSTR])
                                    begin
                                        state_next = S_POP;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end

                    MODE_RX:
                    begin
                        // full drops the byte; either way unread data means overrun
                        if (!rx_stat.full)
                        begin
                            rx_push = 1'b1;
                        end
                        if (!rx_stat.empty)
                        begin
                            ovr_next = 1'b1;
                        end
                    end

                    default: ;
                endcase
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.read_data    = rd_from_rx_reg ? rx_rd_data : rd_hold_reg;
                    rsp_next.tx_valid     = 1'b0;
                    rsp_next.tx_byte      = '0;
                    rsp_next.last         = 1'b1;
                    rsp_next.irq_level    = irq;
                    rsp_next.chip_selects = lines_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_POP:
            begin
                tx_pop     = 1'b1;
                state_next = S_SEND;
            end

            S_SEND:
            begin
                if (rsp_free)
                begin
                    rsp_next.read_data    = '0;
                    rsp_next.tx_valid     = 1'b1;
                    rsp_next.tx_byte      = tx_rd_data;
                    rsp_next.last         = tx_stat.empty;
                    rsp_next.irq_level    = irq;
                    rsp_next.chip_selects = lines_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = tx_stat.empty ? S_IDLE : S_POP;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            ctl_reg        <= '0;
            sel_idx_reg    <= '0;
            ovr_reg        <= 1'b0;
            lines_reg      <= '1;
            rd_hold_reg    <= '0;
            rd_from_rx_reg <= 1'b0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            ctl_reg        <= ctl_next;
            sel_idx_reg    <= sel_idx_next;
            ovr_reg        <= ovr_next;
            lines_reg      <= lines_next;
            rd_hold_reg    <= rd_hold_next;
            rd_from_rx_reg <= rd_from_rx_next;
            rsp_reg        <= rsp_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_drain_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> !tx_stat.empty)
        else $error("drain step with empty tx fifo");
    a_send_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEND |-> $past(state_reg) == S_POP || $past(state_reg) == S_SEND)
        else $error("send state entered without a pop");
    a_lines_high_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl_reg[CTL_SPE] |-> lines_reg == '1)
        else $error("chip select active while disabled");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the SPI master with FIFOs: directed and random register traffic.
`timescale 1ns / 1ps

module tb_top;
    import spimf_pkg::*;

    localparam int DEPTH         = FIFO_DEPTH_DEF;
    localparam int STALL_PCT     = 30;    // chance of an idle cycle on either side
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction before giving up
    localparam int RANDOM_ITEMS  = 250;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_CAP     = 50;

    // control 1 values built from the package bit positions
    localparam logic [7:0] CTL_OFF   = 8'h00;
    localparam logic [7:0] CTL_EN    = 8'(1 << CTL_SPE);
    localparam logic [7:0] CTL_MS    = 8'(1 << CTL_MSTR);
    localparam logic [7:0] CTL_IRQS  = 8'((1 << CTL_TXEIE) | (1 << CTL_RXNEIE) | (1 << CTL_ERRIE));
    localparam logic [7:0] OVR_CLEAR = 8'(1 << STAT_OVR);
    localparam logic [9:0] REG_TOP   = 10'h3FF;  // highest offset, maps to nothing

    typedef struct {
        spimf_req_t req;
        bit         drain_first;  // hold this request until every response is back
    } queued_req_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    spimf_req_t req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    spimf_rsp_t rsp;

    // Stimulus backlog and the responses still owed by the block
    queued_req_t request_backlog[$];
    spimf_rsp_t  owed_rsp[$];

    // Shadow of the block: registers, FIFOs and select lines
    logic [7:0]           ctl_reg   = '0;
    logic [1:0]           sel_reg   = '0;
    logic                 ovr_reg   = 1'b0;
    logic [SEL_LINES-1:0] lines_reg = '1;
    logic [7:0]           tx_bytes[$];
    logic [7:0]           rx_bytes[$];

    // Generator-side view of control 1 and TX fill, used to steer the stimulus
    logic [7:0] gen_ctl  = '0;
    int         gen_fill = 0;

    int requests_done  = 0;
    int responses_seen = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int longest_drain  = 0;
    int rx_overflows   = 0;

    // One stretch of the run with no idling on either side
    logic no_stall;
    assign no_stall = (requests_done >= 140) && (requests_done < 200);

    spi_master_with_fifos_unit #(
        .FIFO_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    function automatic logic [SEL_LINES-1:0] lines_for(input logic [1:0] idx);
        lines_for = '1;
        if (idx < SELECT_COUNT)
        begin
            lines_for[idx] = 1'b0;
        end
    endfunction

    function automatic logic [7:0] status_byte();
        logic [7:0] st;
        st            = '0;
        st[STAT_TXE]  = (tx_bytes.size() == 0);
        st[STAT_RXNE] = (rx_bytes.size() != 0);
        st[STAT_OVR]  = ovr_reg;
        return st;
    endfunction

    function automatic logic irq_now();
        logic [7:0] st;
        st = status_byte();
        return (st[STAT_TXE] & ctl_reg[CTL_TXEIE]) | (st[STAT_RXNE] & ctl_reg[CTL_RXNEIE])
             | (st[STAT_OVR] & ctl_reg[CTL_ERRIE]);
    endfunction

    // Applies one accepted request to the shadow and queues the responses it owes.
    task automatic spi_access_outcome(input spimf_req_t r);
        spimf_rsp_t one;
        logic [7:0] rd;
        logic [7:0] shifted[$];
        bit         waiting;
        int         n;
        rd      = '0;
        shifted = {};
        case (r.mode)
            MODE_READ:
            begin
                case (r.reg_index)
                    REG_CTL1:   rd = ctl_reg;
                    REG_SELECT: rd = {6'd0, sel_reg};
                    REG_STATUS: rd = status_byte();
                    REG_DATA:
                    begin
                        if (rx_bytes.size() != 0)
                        begin
                            rd = rx_bytes.pop_front();
                        end
                        else
                        begin
                            rd = EMPTY_READ;
                        end
                    end
                    default:    rd = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (r.reg_index)
                    REG_CTL1:
                    begin
                        ctl_reg = r.write_data;
                        if (!ctl_reg[CTL_SPE])
                        begin
                            lines_reg = '1;
                        end
                        else if (ctl_reg[CTL_MSTR])
                        begin
                            lines_reg = lines_for(sel_reg);
                        end
                    end
                    REG_SELECT:
                    begin
                        sel_reg = 2'(r.write_data & SEL_MASK);
                        if (ctl_reg[CTL_SPE] && ctl_reg[CTL_MSTR])
                        begin
                            lines_reg = lines_for(sel_reg);
                        end
                    end
                    REG_STATUS:
                    begin
                        if (r.write_data[STAT_OVR])
                        begin
                            ovr_reg = 1'b0;
                        end
                    end
                    REG_DATA:
                    begin
                        if (ctl_reg[CTL_SPE] && tx_bytes.size() < DEPTH)
                        begin
                            tx_bytes.push_back(r.write_data);
                            if (ctl_reg[CTL_MSTR])
                            begin
                                shifted  = tx_bytes;
                                tx_bytes = {};
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_RX:
            begin
                waiting = (rx_bytes.size() != 0);
                if (rx_bytes.size() >= DEPTH)
                begin
                    ovr_reg = 1'b1;
                    rx_overflows++;
                end
                else
                begin
                    rx_bytes.push_back(r.rx_byte);
                    if (waiting)
                    begin
                        ovr_reg = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (shifted.size() > longest_drain)
        begin
            longest_drain = shifted.size();
        end
        n = (shifted.size() != 0) ? shifted.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            one.read_data    = (shifted.size() != 0) ? 8'h00 : rd;
            one.tx_valid     = (shifted.size() != 0);
            one.tx_byte      = (shifted.size() != 0) ? shifted[k] : 8'h00;
            one.last         = (k == n - 1);
            one.irq_level    = irq_now();
            one.chip_selects = lines_reg;
            owed_rsp.push_back(one);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_item(input logic [1:0] m, input logic [9:0] idx,
                              input logic [7:0] wd, input logic [7:0] rb,
                              input bit drain_first = 1'b0);
        queued_req_t q;
        q.req.mode       = m;
        q.req.reg_index  = idx;
        q.req.write_data = wd;
        q.req.rx_byte    = rb;
        q.drain_first    = drain_first;
        request_backlog.push_back(q);
        if (m == MODE_WRITE && idx == REG_CTL1)
        begin
            gen_ctl = wd;
        end
        if (m == MODE_WRITE && idx == REG_DATA && gen_ctl[CTL_SPE] && gen_fill < DEPTH)
        begin
            gen_fill++;
            if (gen_ctl[CTL_MSTR])
            begin
                gen_fill = 0;
            end
        end
    endtask

    // A full TX FIFO can never drain again, so random traffic switches to
    // master mode before the last free slot would be taken.
    task automatic queue_data_write(input logic [7:0] wd);
        if (gen_ctl[CTL_SPE] && !gen_ctl[CTL_MSTR] && gen_fill >= DEPTH - 1)
        begin
            queue_item(MODE_WRITE, REG_CTL1, rnd8() | CTL_EN | CTL_MS, rnd8());
        end
        queue_item(MODE_WRITE, REG_DATA, wd, rnd8());
    endtask

    task automatic queue_directed();
        logic [7:0] fill_pattern[7] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7E};
        queue_item(MODE_READ, REG_CTL1, rnd8(), rnd8());
        queue_item(MODE_READ, REG_STATUS, rnd8(), rnd8());
        queue_item(MODE_READ, REG_DATA, rnd8(), rnd8());        // empty RX reads all ones
        queue_item(MODE_READ, REG_TOP, 8'hFF, 8'hFF);           // unmapped offset reads zero
        queue_item(MODE_WRITE, REG_TOP, 8'hFF, 8'hFF);          // unmapped write dropped
        queue_item(MODE_WRITE, REG_DATA, 8'h5A, rnd8());        // disabled: byte dropped
        queue_item(MODE_NOP, REG_TOP, 8'hFF, 8'hFF);
        queue_item(MODE_RX, REG_CTL1, 8'h00, 8'h00);            // taken even while disabled
        queue_item(MODE_RX, REG_TOP, 8'hFF, 8'hFF);             // unread data waiting: overrun
        queue_item(MODE_WRITE, REG_CTL1, 8'hFF, rnd8());        // every control bit set
        queue_item(MODE_WRITE, REG_SELECT, 8'hFE, rnd8());      // only the low two bits count
        queue_item(MODE_WRITE, REG_SELECT, 8'h03, rnd8());
        queue_item(MODE_WRITE, REG_STATUS, ~OVR_CLEAR, rnd8()); // overrun survives
        queue_item(MODE_READ, REG_STATUS, rnd8(), rnd8());
        queue_item(MODE_WRITE, REG_STATUS, OVR_CLEAR, rnd8());
        queue_item(MODE_READ, REG_DATA, rnd8(), rnd8());
        queue_item(MODE_READ, REG_DATA, rnd8(), rnd8());
        // enabled but not master: bytes pile up, select lines left alone
        queue_item(MODE_WRITE, REG_CTL1, CTL_EN | CTL_IRQS, rnd8());
        foreach (fill_pattern[i])
        begin
            queue_item(MODE_WRITE, REG_DATA, fill_pattern[i], rnd8());
        end
        queue_item(MODE_WRITE, REG_CTL1, CTL_EN | CTL_MS, rnd8());
        // this write drains all eight bytes; wait for the pipe to empty first
        queue_item(MODE_WRITE, REG_DATA, 8'hC3, rnd8(), 1'b1);
        queue_item(MODE_WRITE, REG_CTL1, CTL_OFF, rnd8());      // disable: all lines high
    endtask

    task automatic queue_random_traffic(input int count);
        int start;
        int pick;
        int k;
        logic [7:0] v;
        start = request_backlog.size();
        while (request_backlog.size() - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                queue_data_write(rnd8());
            end
            else if (pick < 37)
            begin
                queue_item(MODE_RX, 10'($urandom), rnd8(), rnd8());
            end
            else if (pick < 50)
            begin
                queue_item(MODE_READ, REG_DATA, rnd8(), rnd8());
            end
            else if (pick < 58)
            begin
                v = rnd8();
                if ($urandom_range(0, 99) < 85)
                begin
                    v[CTL_SPE] = 1'b1;
                end
                queue_item(MODE_WRITE, REG_CTL1, v, rnd8());
            end
            else if (pick < 63)
            begin
                queue_item(MODE_WRITE, REG_SELECT, rnd8(), rnd8());
            end
            else if (pick < 68)
            begin
                queue_item(MODE_WRITE, REG_STATUS, rnd8(), rnd8());
            end
            else if (pick < 75)
            begin
                queue_item(MODE_READ, 10'($urandom_range(REG_CTL1, REG_STATUS)), rnd8(), rnd8());
            end
            else if (pick < 80)
            begin
                queue_item(2'($urandom_range(MODE_READ, MODE_WRITE)),
                           10'($urandom_range(REG_DATA + 1, REG_TOP)), rnd8(), rnd8());
            end
            else if (pick < 83)
            begin
                queue_item(MODE_NOP, 10'($urandom), rnd8(), rnd8());
            end
            else if (pick < 92)
            begin
                // queue a few bytes as non-master, then one master write drains them
                v           = rnd8() | CTL_EN;
                v[CTL_MSTR] = 1'b0;
                queue_item(MODE_WRITE, REG_CTL1, v, rnd8());
                k = $urandom_range(1, DEPTH - 1);
                repeat (k)
                begin
                    queue_data_write(rnd8());
                end
                queue_item(MODE_WRITE, REG_CTL1, v | CTL_MS, rnd8());
                queue_data_write(rnd8());
            end
            else
            begin
                // slave bytes in a row, possibly past full, then some draining reads
                k = $urandom_range(1, DEPTH + 2);
                repeat (k)
                begin
                    queue_item(MODE_RX, 10'($urandom), rnd8(), rnd8());
                end
                repeat ($urandom_range(0, k + 1))
                begin
                    queue_item(MODE_READ, REG_DATA, rnd8(), rnd8());
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_item(MODE_WRITE, REG_STATUS, OVR_CLEAR, rnd8());
                end
            end
        end
    endtask

    // Fills TX to the brim; later data writes are dropped, even in master mode.
    task automatic queue_full_tx();
        int room;
        queue_item(MODE_WRITE, REG_CTL1, CTL_EN, rnd8());
        room = DEPTH - gen_fill;
        repeat (room + 1)
        begin
            queue_item(MODE_WRITE, REG_DATA, rnd8(), rnd8());
        end
        queue_item(MODE_WRITE, REG_CTL1, CTL_EN | CTL_MS | CTL_IRQS, rnd8());
        queue_item(MODE_WRITE, REG_DATA, rnd8(), rnd8());
        queue_item(MODE_READ, REG_STATUS, rnd8(), rnd8());
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    function automatic bit may_issue();
        if (request_backlog.size() == 0)
        begin
            return 1'b0;
        end
        if (request_backlog[0].drain_first && owed_rsp.size() != 0)
        begin
            return 1'b0;
        end
        return no_stall || ($urandom_range(0, 99) >= STALL_PCT);
    endfunction

    // Valid is only dropped or reloaded when no transaction is pending, so the
    // payload holds steady while the block stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                spi_access_outcome(req);
                requests_done++;
            end
            if (!req_valid || req_ready)
            begin
                if (may_issue())
                begin
                    req_valid <= 1'b1;
                    req       <= request_backlog[0].req;
                    void'(request_backlog.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor and checks
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
        begin
            $display("[%0t] MISMATCH response %0d: %s", $realtime, responses_seen, what);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%02h, want 0x%02h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        spimf_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction 0x%h", rsp));
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("read_data", rsp.read_data, want.read_data);
                    check_field("tx_valid", 8'(rsp.tx_valid), 8'(want.tx_valid));
                    check_field("tx_byte", rsp.tx_byte, want.tx_byte);
                    check_field("last", 8'(rsp.last), 8'(want.last));
                    check_field("irq_level", 8'(rsp.irq_level), 8'(want.irq_level));
                    check_field("chip_selects", 8'(rsp.chip_selects), 8'(want.chip_selects));
                end
                responses_seen++;
            end
            rsp_ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    // Watchdog: a run with no transaction on either side for too long is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no transaction in %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial
    begin
        queue_directed();
        queue_random_traffic(RANDOM_ITEMS / 2);
        // mid-run pause: let every owed response come back before going on
        queue_item(MODE_READ, REG_STATUS, rnd8(), rnd8(), 1'b1);
        queue_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        queue_full_tx();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_valid || owed_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests, checked %0d responses;", requests_done, responses_seen);
        $display("longest TX drain %0d bytes, %0d RX overflows.", longest_drain, rx_overflows);
        $display("Traffic hit every register, unmapped offsets, no-ops, slave bytes and full FIFOs.");
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/spimf_pkg.sv
rtl/spimf_fifo.sv
rtl/spi_master_with_fifos_unit.sv
test/tb_top.sv
